>>> sv/deadline_timer_queue_unit_defines.svh
// Assertion macros used by the checker of the deadline timer queue.
// No dependencies; include by bare file name.
`ifndef DEADLINE_TIMER_QUEUE_UNIT_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dtq assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dtq assertion failed");

`endif

>>> sv/dtq_pkg.sv
// Types and constants of the deadline timer queue.
// No dependencies; used by every module of the block but dtq_ram.
package dtq_pkg;

	typedef enum logic [1:0] {
		FUNC_ONESHOT  = 2'd0,
		FUNC_PERIODIC = 2'd1,
		FUNC_CANCEL   = 2'd2,
		FUNC_CHECK    = 2'd3
	} func_t;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_FULL       = 2'd1;
	localparam logic [1:0] STATUS_BAD_HANDLE = 2'd2;

	typedef struct packed {
		func_t       func;
		logic [63:0] now_time;
		logic [63:0] interval;
		logic [15:0] callback_id;
		logic [3:0]  handle;
	} in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [3:0]         slot;
		logic               fired;
		logic [15:0]        fired_callback;
		logic               more_due;
		logic signed [63:0] next_delta;
	} out_t;

	// One timer entry as kept in the slot memory.
	typedef struct packed {
		logic [63:0] deadline;
		logic [63:0] period;
		logic [15:0] tag;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_CANCEL,
		ST_SCAN,
		ST_DRAIN,
		ST_POP,
		ST_FIN,
		ST_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic cnt_clr;
		logic cnt_inc;
		logic rd_en;
		logic alloc;
		logic alloc_full;
		logic cancel;
		logic pop;
		logic fin;
		logic out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cnt_last;
		logic cnt_free;
		logic out_free;
	} dp_sts_t;

endpackage

>>> sv/dtq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/dtq_ctrl.sv
// Sequencing state machine of the deadline timer queue.
// Depends on dtq_pkg; drives the commands of dtq_datapath.
module dtq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  dtq_pkg::func_t   in_func,
	output logic             in_ready,
	output dtq_pkg::dp_cmd_t cmd,
	input  dtq_pkg::dp_sts_t sts
);

	dtq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			dtq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					cmd.cnt_clr = 1'b1;
					unique case (in_func)
						dtq_pkg::FUNC_ONESHOT,
						dtq_pkg::FUNC_PERIODIC: state_d = dtq_pkg::ST_ALLOC;
						dtq_pkg::FUNC_CANCEL:   state_d = dtq_pkg::ST_CANCEL;
						dtq_pkg::FUNC_CHECK:    state_d = dtq_pkg::ST_SCAN;
						default:                state_d = dtq_pkg::ST_IDLE;
					endcase
				end
			end
			dtq_pkg::ST_ALLOC: begin
				priority if (sts.cnt_free) begin
					cmd.alloc = 1'b1;
					state_d   = dtq_pkg::ST_RESULT;
				end else if (sts.cnt_last) begin
					cmd.alloc_full = 1'b1;
					state_d        = dtq_pkg::ST_RESULT;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			dtq_pkg::ST_CANCEL: begin
				cmd.cancel = 1'b1;
				state_d    = dtq_pkg::ST_RESULT;
			end
			dtq_pkg::ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (sts.cnt_last) begin
					state_d = dtq_pkg::ST_DRAIN;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			dtq_pkg::ST_DRAIN: begin
				state_d = dtq_pkg::ST_POP;
			end
			dtq_pkg::ST_POP: begin
				cmd.pop = 1'b1;
				state_d = dtq_pkg::ST_FIN;
			end
			dtq_pkg::ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = dtq_pkg::ST_RESULT;
			end
			dtq_pkg::ST_RESULT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = dtq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dtq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> sv/dtq_datapath.sv
// Slot table, deadline scan and result register of the deadline timer queue.
// Depends on dtq_pkg and dtq_ram; steered by dtq_ctrl.
module dtq_datapath #(
	parameter int NUM_TIMERS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dtq_pkg::dp_cmd_t cmd,
	output dtq_pkg::dp_sts_t sts,
	input  dtq_pkg::in_t     in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output dtq_pkg::out_t    out_item
);

	localparam int IW = $clog2(NUM_TIMERS);
	localparam int HW = (IW > 4) ? IW : 4;

	dtq_pkg::in_t   item_q;
	logic [IW-1:0]  cnt_q;
	logic [NUM_TIMERS-1:0] used_q;
	logic [NUM_TIMERS-1:0] dis_q;

	logic           rd_vld_s1;
	logic [IW-1:0]  idx_s1;
	logic [dtq_pkg::ENTRY_W-1:0] rd_data;
	dtq_pkg::entry_t rd_entry;

	logic            best_vld_q;
	logic [IW-1:0]   best_idx_q;
	dtq_pkg::entry_t best_q;
	logic            sec_vld_q;
	logic [IW-1:0]   sec_idx_q;
	logic [63:0]     sec_dl_q;

	logic            due_q;
	logic            rearm_q;
	logic [63:0]     nd_q;
	logic            fin_vld_q;
	logic [63:0]     fin_dl_q;

	logic [1:0]      status_q;
	logic [3:0]      slot_q;
	logic            fired_q;
	logic [15:0]     fcb_q;
	logic            out_valid_q;
	dtq_pkg::out_t   out_q;

	logic [HW-1:0]   cnt_ext;
	logic [HW-1:0]   h_ext;
	logic [IW-1:0]   h_idx;
	logic            cancel_ok;
	logic            scan_hit;
	logic            pop_due;
	logic            pop_dis;
	logic            pop_rearm;
	logic [63:0]     rearm_dl;
	logic            nd_wins;
	logic            is_check;

	logic            ram_we;
	logic [IW-1:0]   ram_waddr;
	dtq_pkg::entry_t wr_entry;

	assign cnt_ext   = HW'(cnt_q);
	assign h_ext     = HW'(item_q.handle);
	assign h_idx     = h_ext[IW-1:0];
	assign cancel_ok = (32'(item_q.handle) < NUM_TIMERS) && used_q[h_idx];

	assign sts.cnt_last = (cnt_q == IW'(NUM_TIMERS - 1));
	assign sts.cnt_free = !used_q[cnt_q];
	assign sts.out_free = !out_valid_q || out_ready;

	assign rd_entry  = rd_data;
	assign scan_hit  = rd_vld_s1 && used_q[idx_s1];

	assign pop_due   = best_vld_q && (best_q.deadline < item_q.now_time);
	assign pop_dis   = dis_q[best_idx_q];
	assign pop_rearm = pop_due && !pop_dis && (best_q.period != 64'd0);
	assign rearm_dl  = best_q.deadline + best_q.period;

	// A re-armed entry keeps its slot, so ties against the runner-up go by index.
	assign nd_wins = !sec_vld_q || (nd_q < sec_dl_q) ||
		((nd_q == sec_dl_q) && (best_idx_q < sec_idx_q));

	assign is_check = (item_q.func == dtq_pkg::FUNC_CHECK);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		wr_entry  = best_q;
		if (cmd.alloc) begin
			ram_we       = 1'b1;
			wr_entry.tag = item_q.callback_id;
			if (item_q.func == dtq_pkg::FUNC_ONESHOT) begin
				wr_entry.deadline = item_q.now_time + item_q.interval;
				wr_entry.period   = 64'd0;
			end else begin
				wr_entry.deadline = item_q.now_time;
				wr_entry.period   = item_q.interval;
			end
		end else if (cmd.pop && pop_rearm) begin
			ram_we            = 1'b1;
			ram_waddr         = best_idx_q;
			wr_entry.deadline = rearm_dl;
		end
	end

	dtq_ram #(
		.WIDTH(dtq_pkg::ENTRY_W),
		.DEPTH(NUM_TIMERS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wr_entry),
		.re   (cmd.rd_en),
		.raddr(cnt_q),
		.rdata(rd_data)
	);

	// Control state: slot flags, scan bookkeeping and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			dis_q       <= '0;
			rd_vld_s1   <= 1'b0;
			best_vld_q  <= 1'b0;
			sec_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.alloc) begin
				used_q[cnt_q] <= 1'b1;
				dis_q[cnt_q]  <= 1'b0;
			end
			if (cmd.cancel && cancel_ok) begin
				dis_q[h_idx] <= 1'b1;
			end
			if (cmd.pop && pop_due && !pop_rearm) begin
				used_q[best_idx_q] <= 1'b0;
			end
			if (cmd.capture) begin
				best_vld_q <= 1'b0;
				sec_vld_q  <= 1'b0;
			end else if (scan_hit) begin
				if (!best_vld_q || (rd_entry.deadline < best_q.deadline)) begin
					best_vld_q <= 1'b1;
					sec_vld_q  <= best_vld_q;
				end else if (!sec_vld_q || (rd_entry.deadline < sec_dl_q)) begin
					sec_vld_q <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (cmd.capture) begin
			item_q   <= in_item;
			status_q <= dtq_pkg::STATUS_OK;
			slot_q   <= 4'd0;
			fired_q  <= 1'b0;
			fcb_q    <= 16'd0;
		end
		if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= IW'(cnt_q + 1'b1);
		end
		if (cmd.alloc) begin
			slot_q <= cnt_ext[3:0];
		end
		if (cmd.alloc_full) begin
			status_q <= dtq_pkg::STATUS_FULL;
		end
		if (cmd.cancel && !cancel_ok) begin
			status_q <= dtq_pkg::STATUS_BAD_HANDLE;
		end
		if (scan_hit) begin
			if (!best_vld_q || (rd_entry.deadline < best_q.deadline)) begin
				sec_idx_q  <= best_idx_q;
				sec_dl_q   <= best_q.deadline;
				best_idx_q <= idx_s1;
				best_q     <= rd_entry;
			end else if (!sec_vld_q || (rd_entry.deadline < sec_dl_q)) begin
				sec_idx_q <= idx_s1;
				sec_dl_q  <= rd_entry.deadline;
			end
		end
		if (cmd.pop) begin
			due_q   <= pop_due;
			rearm_q <= pop_rearm;
			nd_q    <= rearm_dl;
			if (pop_due && !pop_dis && (best_q.tag != 16'd0)) begin
				fired_q <= 1'b1;
				fcb_q   <= best_q.tag;
			end
		end
		if (cmd.fin) begin
			priority if (!due_q) begin
				fin_vld_q <= best_vld_q;
				fin_dl_q  <= best_q.deadline;
			end else if (rearm_q) begin
				fin_vld_q <= 1'b1;
				fin_dl_q  <= nd_wins ? nd_q : sec_dl_q;
			end else begin
				fin_vld_q <= sec_vld_q;
				fin_dl_q  <= sec_dl_q;
			end
		end
		if (cmd.out_load) begin
			out_q.status         <= status_q;
			out_q.slot           <= slot_q;
			out_q.fired          <= fired_q;
			out_q.fired_callback <= fcb_q;
			out_q.more_due       <= is_check && fin_vld_q && (fin_dl_q < item_q.now_time);
			out_q.next_delta     <= (is_check && fin_vld_q) ?
				$signed(fin_dl_q - item_q.now_time) : 64'sd0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

>>> sv/deadline_timer_queue_unit.sv
// Deadline timer queue: a cancel passes through the cancel and result states, a
// registration searches the slots in turn for a free one, and a check scans
// every slot (one slot memory read per cycle), then pops and selects.
// One request is in flight at a time; the next is accepted the cycle after the
// result is loaded. Reset clears the used and disabled flags at once; the slot
// memory needs no pass.
module deadline_timer_queue_unit #(
	parameter int NUM_TIMERS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  dtq_pkg::in_t  in_item,
	output logic          out_valid,
	input  logic          out_ready,
	output dtq_pkg::out_t out_item
);

	// The controller walks each request through its phases: a free-slot
	// search for registrations, a single flag update for cancel, and for a
	// check a full deadline scan that keeps the earliest and the runner-up
	// entry, followed by the pop and the choice of the new earliest deadline.
	dtq_pkg::dp_cmd_t cmd;
	dtq_pkg::dp_sts_t sts;

	dtq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_func (in_item.func),
		.in_ready(in_ready),
		.cmd     (cmd),
		.sts     (sts)
	);

	// The datapath holds the slot flags, the timer memory, the scan registers
	// and the result register that lets the next request enter while a
	// finished result still waits downstream.
	dtq_datapath #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

endmodule

>>> sv/dtq_checker.sv
// Port-level checks for the deadline timer queue, bound to the top level.
// Depends on dtq_pkg and deadline_timer_queue_unit_defines.svh.
`include "deadline_timer_queue_unit_defines.svh"

module dtq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input dtq_pkg::in_t  in_item,
	input logic          out_valid,
	input logic          out_ready,
	input dtq_pkg::out_t out_item
);

	// A stalled result holds its value until taken.
	`DTQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_item))

	// Only one request is worked on at a time.
	`DTQ_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready)

	// A callback tag is reported only when a timer fired, and then it is nonzero.
	`DTQ_ASSERT_NOW(a_fired_tag, clk, arst_n, out_valid, out_item.fired == (out_item.fired_callback != 16'd0))

	// A failed request never reports a slot.
	`DTQ_ASSERT_NOW(a_fail_slot, clk, arst_n, out_valid && out_item.status != dtq_pkg::STATUS_OK, out_item.slot == 4'd0)

endmodule

bind deadline_timer_queue_unit dtq_checker u_dtq_checker (.*);
